[rtl/core/ptst_pkg.sv]
// ----------------------------------------------------------------------------
// ptst_pkg
// Shared types, codes and helpers for the periodic task slot timer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptst_pkg;

  localparam int SLOTS   = 8;
  localparam int ID_BITS = 8;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // input operation codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  // result kind codes
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_FIRE = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  task_id;
    logic [15:0] period;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ok;
    logic [2:0] slot;
    logic [7:0] fired_id;
    logic       last;
  } out_word_t;

  // request word travelling along the row of slots
  typedef struct packed {
    logic               vld;
    logic [1:0]         op;
    logic [ID_BITS-1:0] id;
    logic [15:0]        period;
  } tok_t;

  // result travelling along the row; at most one slot raises emit per cycle
  typedef struct packed {
    logic      emit;
    out_word_t word;
  } res_link_t;

  function automatic logic [ID_BITS-1:0] id_of(input logic [7:0] x);
    logic [ID_BITS+7:0] w;
    w = {{ID_BITS{1'b0}}, x};
    return w[ID_BITS-1:0];
  endfunction

  function automatic logic [7:0] id_to8(input logic [ID_BITS-1:0] x);
    logic [ID_BITS+7:0] w;
    w = {8'd0, x};
    return w[7:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/ptst_cell.sv]
// ----------------------------------------------------------------------------
// ptst_cell
// One task slot: holds busy flag, tick count, limit and owner id, serves the
// request word when it arrives and hands it on to the next slot unless it took it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptst_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ptst_pkg::SLOT_W-1:0]  slot_idx,
  input  logic                         adv,
  input  ptst_pkg::tok_t               tok_in,
  output ptst_pkg::tok_t               tok_out,
  input  logic                         later_in,
  output logic                         later_out,
  input  ptst_pkg::res_link_t          res_in,
  output ptst_pkg::res_link_t          res_out,
  output logic                         tok_vld
);

  ptst_pkg::tok_t                tok_r, tok_nxt;
  logic                          busy_r, busy_nxt;
  logic [15:0]                   cnt_r, cnt_nxt;
  logic [15:0]                   lim_r, lim_nxt;
  logic [ptst_pkg::ID_BITS-1:0]  own_r, own_nxt;

  logic [16:0]                   cnt_inc;
  logic                          due;
  logic                          is_last;
  logic [ptst_pkg::SLOT_W+2:0]   idx_w;
  logic                          act;
  logic                          pass;
  logic                          emit;
  ptst_pkg::out_word_t           mine;

  assign cnt_inc   = {1'b0, cnt_r} + 17'd1;
  assign due       = busy_r && (cnt_inc > {1'b0, lim_r});
  assign later_out = due | later_in;
  assign is_last   = (slot_idx == ptst_pkg::SLOT_W'(ptst_pkg::SLOTS - 1));
  assign idx_w     = {3'b000, slot_idx};
  assign act       = tok_r.vld && adv;
  assign tok_vld   = tok_r.vld;

  always_comb begin
    pass     = 1'b1;
    emit     = 1'b0;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    lim_nxt  = lim_r;
    own_nxt  = own_r;
    mine.kind     = ptst_pkg::KIND_FIRE;
    mine.ok       = 1'b1;
    mine.slot     = idx_w[2:0];
    mine.fired_id = ptst_pkg::id_to8(own_r);
    mine.last     = 1'b1;
    case (tok_r.op)
      ptst_pkg::OP_TICK: begin
        if (busy_r) begin
          if (due) begin
            cnt_nxt   = 16'd0;
            emit      = 1'b1;
            mine.last = !later_in;
          end else begin
            cnt_nxt = cnt_inc[15:0];
          end
        end
      end
      ptst_pkg::OP_ADD: begin
        mine.kind     = ptst_pkg::KIND_ADD;
        mine.fired_id = ptst_pkg::id_to8(tok_r.id);
        if (!busy_r) begin
          busy_nxt = 1'b1;
          cnt_nxt  = 16'd0;
          lim_nxt  = tok_r.period - 16'd1;
          own_nxt  = tok_r.id;
          emit     = 1'b1;
          pass     = 1'b0;
        end else if (is_last) begin
          emit      = 1'b1;
          mine.ok   = 1'b0;
          mine.slot = 3'd0;
        end
      end
      ptst_pkg::OP_DEL: begin
        mine.kind     = ptst_pkg::KIND_DEL;
        mine.fired_id = ptst_pkg::id_to8(tok_r.id);
        if (busy_r && (own_r == tok_r.id)) begin
          busy_nxt = 1'b0;
          emit     = 1'b1;
          pass     = 1'b0;
        end else if (is_last) begin
          emit      = 1'b1;
          mine.ok   = 1'b0;
          mine.slot = 3'd0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    tok_out     = tok_r;
    tok_out.vld = act && pass && !is_last;
    if (act && emit) begin
      res_out.emit = 1'b1;
      res_out.word = mine;
    end else begin
      res_out = res_in;
    end
    // hold a stalled word, otherwise take whatever the previous slot hands on
    tok_nxt = (tok_r.vld && !adv) ? tok_r : tok_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
      busy_r    <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
      if (act) begin
        busy_r <= busy_nxt;
      end
    end
    tok_r.op     <= tok_nxt.op;
    tok_r.id     <= tok_nxt.id;
    tok_r.period <= tok_nxt.period;
  end

  always_ff @(posedge clk) begin
    if (act) begin
      cnt_r <= cnt_nxt;
      lim_r <= lim_nxt;
      own_r <= own_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/periodic_task_slot_timer_top.sv]
// Flow: a word enters slot 0 at the accepting edge and visits one slot per cycle
//   while the output register can take a result; results are registered in out_word.
// A new word is taken only once the slot row is empty (a tick always walks every slot;
//   an add or delete stops at its slot).
// Reset: synchronous, active low; all slots free, no word in flight, no result.
// ----------------------------------------------------------------------------
// periodic_task_slot_timer_top
// Bank of periodic task slots built as a row of slot cells with one output
// register; add, delete and tick words walk the row one slot per cycle unless it stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_slot_timer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ptst_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptst_pkg::out_word_t  out_word
);

  ptst_pkg::tok_t       tok_link   [0:ptst_pkg::SLOTS];
  ptst_pkg::res_link_t  res_link   [0:ptst_pkg::SLOTS];
  logic                 later_link [0:ptst_pkg::SLOTS];
  logic [ptst_pkg::SLOTS-1:0] tok_vld;

  logic                 in_acc;
  logic                 adv;
  logic                 out_vld_r, out_vld_nxt;
  ptst_pkg::out_word_t  out_r, out_nxt;

  assign in_stall = |tok_vld;
  assign in_acc   = in_valid && !in_stall;
  // the row moves only when the output register can take a result
  assign adv      = !out_vld_r || !out_stall;

  assign tok_link[0].vld    = in_acc;
  assign tok_link[0].op     = in_word.op;
  assign tok_link[0].id     = ptst_pkg::id_of(in_word.task_id);
  assign tok_link[0].period = in_word.period;
  assign res_link[0]        = '0;
  assign later_link[ptst_pkg::SLOTS] = 1'b0;

  for (genvar i = 0; i < ptst_pkg::SLOTS; i++) begin : g_slot
    ptst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .slot_idx  (ptst_pkg::SLOT_W'(i)),
      .adv       (adv),
      .tok_in    (tok_link[i]),
      .tok_out   (tok_link[i+1]),
      .later_in  (later_link[i+1]),
      .later_out (later_link[i]),
      .res_in    (res_link[i]),
      .res_out   (res_link[i+1]),
      .tok_vld   (tok_vld[i])
    );
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (res_link[ptst_pkg::SLOTS].emit && adv) begin
      out_vld_nxt = 1'b1;
      out_nxt     = res_link[ptst_pkg::SLOTS].word;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_r;

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one word in the slot row");

  a_enter_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> tok_vld[0])
    else $error("accepted word did not enter slot 0");

  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    !tok_link[ptst_pkg::SLOTS].vld)
    else $error("word handed past the last slot");

  a_emit_adv: assert property (@(posedge clk) disable iff (!rst_n)
    res_link[ptst_pkg::SLOTS].emit |-> (adv && (|tok_vld)))
    else $error("result raised without a word in flight or room to hold it");

  a_fire_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_link[ptst_pkg::SLOTS].emit &&
     (res_link[ptst_pkg::SLOTS].word.kind == ptst_pkg::KIND_FIRE) &&
     !res_link[ptst_pkg::SLOTS].word.last) |-> later_link[0])
    else $error("fire marked not last with no later slot due");

endmodule

`default_nettype wire
